@@ rtl/csts_pkg.sv @@
`default_nettype none
package csts_pkg;

    localparam int MAX_VECTORS_DEF = 2048;
    localparam int MAX_DIM_DEF     = 32;

    localparam logic [1:0] OP_STORE = 2'd0;
    localparam logic [1:0] OP_QUERY = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [2:0] ST_STORED  = 3'd0;
    localparam logic [2:0] ST_FULL    = 3'd1;
    localparam logic [2:0] ST_MATCH   = 3'd2;
    localparam logic [2:0] ST_DONE    = 3'd3;
    localparam logic [2:0] ST_EMPTY   = 3'd4;
    localparam logic [2:0] ST_CLEARED = 3'd5;

    localparam logic [1:0] CFG_VLEN = 2'd0;
    localparam logic [1:0] CFG_THR  = 2'd1;
    localparam logic [1:0] CFG_MAXM = 2'd2;

    localparam logic [5:0]  VLEN_RST = 6'd32;
    localparam logic [14:0] THR_RST  = 15'd16384;
    localparam logic [5:0]  MAXM_RST = 6'd1;

    localparam int DIV_STEPS  = 31;
    localparam int SQRT_STEPS = 16;

    typedef enum logic [2:0] {
        DP_NONE,
        DP_MULP_INIT,
        DP_MUL_STEP,
        DP_MULD_INIT,
        DP_DIV_INIT,
        DP_DIV_STEP,
        DP_SQRT_INIT,
        DP_SQRT_STEP
    } t_dpop;

    typedef struct packed {
        logic       mem_we;
        logic       q_we;
        logic       wr_zero;
        logic       rd_en;
        logic       acc_clr;
        t_dpop      dp_op;
        logic       out_load;
        logic [2:0] out_status;
        logic       out_sim_en;
        logic       out_last;
    } t_cmd;

    typedef struct packed {
        logic        ma_zero;
        logic        mb_zero;
        logic        dot_neg;
        logic [14:0] sim;
    } t_sts;

endpackage
`default_nettype wire

@@ rtl/csts_if.sv @@
`default_nettype none
interface csts_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         operation;
    logic signed [15:0] element_value;
    logic               last_element;
    modport source (output valid, operation, element_value, last_element, input ready);
    modport sink   (input valid, operation, element_value, last_element, output ready);
endinterface

interface csts_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [11:0] concept_id;
    logic [14:0] similarity;
    logic [5:0]  match_count;
    logic        last_result;
    modport source (output valid, status, concept_id, similarity, match_count, last_result,
                    input ready);
    modport sink   (input valid, status, concept_id, similarity, match_count, last_result,
                    output ready);
endinterface

interface csts_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ rtl/csts_dp.sv @@
`default_nettype none
module csts_dp #(
    parameter int MAX_VECTORS = csts_pkg::MAX_VECTORS_DEF,
    parameter int MAX_DIM     = csts_pkg::MAX_DIM_DEF,
    localparam int SW = $clog2(MAX_VECTORS),
    localparam int DW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  csts_pkg::t_cmd      i_cmd,
    input  wire [SW-1:0]        i_slot,
    input  wire [DW-1:0]        i_idx,
    input  wire signed [15:0]   i_value,
    input  wire [11:0]          i_out_id,
    input  wire [5:0]           i_out_count,
    output csts_pkg::t_sts      o_sts,
    output logic [2:0]          o_status,
    output logic [11:0]         o_concept_id,
    output logic [14:0]         o_similarity,
    output logic [5:0]          o_match_count,
    output logic                o_last_result
);
    localparam int DEPTH = MAX_VECTORS * (2 ** DW);
    localparam int AW    = 32 + DW;
    localparam int MW    = 2 * AW;

    logic signed [15:0] r_mem [0:DEPTH-1];
    logic signed [15:0] r_qv  [0:(2**DW)-1];
    logic signed [15:0] r_a, r_b;
    logic               r_v1, r_v2;
    logic signed [31:0] r_pab;
    logic [31:0]        r_paa, r_pbb;
    logic signed [AW-1:0] r_dot;
    logic [AW-1:0]      r_ma, r_mb;
    logic [MW-1:0]      r_mx, r_macc, r_p, r_rem;
    logic [AW-1:0]      r_my;
    logic               r_sbit;
    logic [30:0]        r_q;
    logic [15:0]        r_root, r_sqb;

    logic signed [31:0] w_a, w_b;
    logic [MW:0]        w_t;
    logic [15:0]        w_rt;
    logic [31:0]        w_sq;
    logic [14:0]        w_sim;

    assign w_a   = 32'(r_a);
    assign w_b   = 32'(r_b);
    assign w_t   = {r_rem, r_sbit};
    assign w_rt  = r_root | r_sqb;
    assign w_sq  = 32'(w_rt) * 32'(w_rt);
    assign w_sim = r_root[15] ? 15'h7fff : r_root[14:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_we) begin
            r_mem[{i_slot, i_idx}] <= i_cmd.wr_zero ? 16'sd0 : i_value;
        end
        if (i_cmd.rd_en) begin
            r_b <= r_mem[{i_slot, i_idx}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.q_we) begin
            r_qv[i_idx] <= i_cmd.wr_zero ? 16'sd0 : i_value;
        end
        if (i_cmd.rd_en) begin
            r_a <= r_qv[i_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.rd_en;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pab <= w_a * w_b;
        r_paa <= $unsigned(w_a * w_a);
        r_pbb <= $unsigned(w_b * w_b);
        if (i_cmd.acc_clr) begin
            r_dot <= '0;
            r_ma  <= '0;
            r_mb  <= '0;
        end else if (r_v2) begin
            r_dot <= r_dot + {{(AW-32){r_pab[31]}}, r_pab};
            r_ma  <= r_ma + {{(AW-32){1'b0}}, r_paa};
            r_mb  <= r_mb + {{(AW-32){1'b0}}, r_pbb};
        end
    end

    // shift-add multiplier, restoring divider and bitwise square root
    always_ff @(posedge i_clk) begin
        case (i_cmd.dp_op)
            csts_pkg::DP_MULP_INIT: begin
                r_mx   <= MW'(r_ma);
                r_my   <= r_mb;
                r_macc <= '0;
            end
            csts_pkg::DP_MUL_STEP: begin
                if (r_my[0]) begin
                    r_macc <= r_macc + r_mx;
                end
                r_mx <= r_mx << 1;
                r_my <= r_my >> 1;
            end
            csts_pkg::DP_MULD_INIT: begin
                r_p    <= r_macc;
                r_mx   <= MW'($unsigned(r_dot));
                r_my   <= $unsigned(r_dot);
                r_macc <= '0;
            end
            csts_pkg::DP_DIV_INIT: begin
                r_rem  <= r_macc >> 1;
                r_sbit <= r_macc[0];
                r_q    <= '0;
            end
            csts_pkg::DP_DIV_STEP: begin
                if (w_t >= {1'b0, r_p}) begin
                    r_rem <= MW'(w_t - {1'b0, r_p});
                    r_q   <= {r_q[29:0], 1'b1};
                end else begin
                    r_rem <= MW'(w_t);
                    r_q   <= {r_q[29:0], 1'b0};
                end
                r_sbit <= 1'b0;
            end
            csts_pkg::DP_SQRT_INIT: begin
                r_root <= '0;
                r_sqb  <= 16'h8000;
            end
            csts_pkg::DP_SQRT_STEP: begin
                if (w_sq <= {1'b0, r_q}) begin
                    r_root <= w_rt;
                end
                r_sqb <= r_sqb >> 1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_status      <= i_cmd.out_status;
            o_concept_id  <= i_out_id;
            o_similarity  <= i_cmd.out_sim_en ? w_sim : 15'd0;
            o_match_count <= i_out_count;
            o_last_result <= i_cmd.out_last;
        end
    end

    assign o_sts.ma_zero = (r_ma == '0);
    assign o_sts.mb_zero = (r_mb == '0);
    assign o_sts.dot_neg = r_dot[AW-1];
    assign o_sts.sim     = w_sim;

endmodule
`default_nettype wire

@@ rtl/csts_ctrl.sv @@
`default_nettype none
module csts_ctrl #(
    parameter int MAX_VECTORS = csts_pkg::MAX_VECTORS_DEF,
    parameter int MAX_DIM     = csts_pkg::MAX_DIM_DEF,
    localparam int SW = $clog2(MAX_VECTORS),
    localparam int DW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_cfg_valid,
    input  wire [1:0]       i_cfg_index,
    input  wire [15:0]      i_cfg_data,
    output logic            o_cfg_ready,
    input  wire             i_in_valid,
    input  wire [1:0]       i_op,
    input  wire             i_last,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  wire             i_out_ready,
    input  csts_pkg::t_sts  i_sts,
    output csts_pkg::t_cmd  o_cmd,
    output logic [SW-1:0]   o_slot,
    output logic [DW-1:0]   o_idx,
    output logic [11:0]     o_out_id,
    output logic [5:0]      o_out_count
);
    localparam int CW  = $clog2(MAX_VECTORS + 1);
    localparam int IW  = $clog2(MAX_DIM + 1);
    localparam int AW  = 32 + DW;
    localparam int CNW = $clog2(AW + 32);

    typedef enum logic [15:0] {
        S_IDLE   = 16'h0001,
        S_ZFILL  = 16'h0002,
        S_RD     = 16'h0004,
        S_DRAIN  = 16'h0008,
        S_CHECK  = 16'h0010,
        S_MULP   = 16'h0020,
        S_MULD_I = 16'h0040,
        S_MULD   = 16'h0080,
        S_DIV_I  = 16'h0100,
        S_DIV    = 16'h0200,
        S_SQRT_I = 16'h0400,
        S_SQRT   = 16'h0800,
        S_JUDGE  = 16'h1000,
        S_EMIT   = 16'h2000,
        S_NEXT   = 16'h4000,
        S_DONE   = 16'h8000
    } t_state;

    t_state          r_state, n_state;
    logic [5:0]      r_vlen;
    logic [14:0]     r_thr;
    logic [5:0]      r_maxm;
    logic [CW-1:0]   r_stored, n_stored;
    logic [IW-1:0]   r_eidx, n_eidx;
    logic [SW-1:0]   r_slot, n_slot;
    logic [IW-1:0]   r_zi, n_zi;
    logic            r_zq, n_zq;
    logic            r_scan, n_scan;
    logic [IW-1:0]   r_ei, n_ei;
    logic [CNW-1:0]  r_cnt, n_cnt;
    logic [5:0]      r_found, n_found;
    logic            r_simz, n_simz;
    logic            r_out_valid;

    logic [31:0]     w_len32;
    logic [IW-1:0]   w_len, w_idx_n, w_filled;
    logic            w_room, w_tgt, w_ofree, w_acc;
    t_state          w_scan_st;

    assign w_len32 = (r_vlen == 6'd0) ? 32'd1 :
                     ((32'(r_vlen) > MAX_DIM) ? 32'(MAX_DIM) : 32'(r_vlen));
    assign w_len    = IW'(w_len32);
    assign w_room   = (32'(r_stored) < MAX_VECTORS);
    assign w_tgt    = ((i_op == csts_pkg::OP_STORE) && w_room) || (i_op == csts_pkg::OP_QUERY);
    assign w_idx_n  = (32'(r_eidx) < MAX_DIM) ? r_eidx + 1'b1 : r_eidx;
    assign w_filled = (w_idx_n < w_len) ? w_idx_n : w_len;
    assign w_ofree  = !r_out_valid || i_out_ready;
    assign w_scan_st = (r_maxm == 6'd0) ? S_DONE : S_RD;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE) && w_ofree;
    assign o_out_valid = r_out_valid;
    assign w_acc       = i_in_valid && o_in_ready;

    always_comb begin
        n_state  = r_state;
        n_stored = r_stored;
        n_eidx   = r_eidx;
        n_slot   = r_slot;
        n_zi     = r_zi;
        n_zq     = r_zq;
        n_scan   = r_scan;
        n_ei     = r_ei;
        n_cnt    = r_cnt;
        n_found  = r_found;
        n_simz   = r_simz;
        o_cmd    = '0;
        o_cmd.dp_op = csts_pkg::DP_NONE;
        o_out_id    = 12'd0;
        o_out_count = 6'd0;
        o_slot   = r_slot;
        o_idx    = r_ei[DW-1:0];

        unique case (r_state)
            S_IDLE: begin
                o_slot = r_stored[SW-1:0];
                o_idx  = r_eidx[DW-1:0];
                if (w_acc) begin
                    case (i_op)
                        csts_pkg::OP_CLEAR: begin
                            n_stored = '0;
                            n_eidx   = '0;
                            o_cmd.out_load   = 1'b1;
                            o_cmd.out_status = csts_pkg::ST_CLEARED;
                            o_cmd.out_last   = 1'b1;
                        end
                        csts_pkg::OP_STORE, csts_pkg::OP_QUERY: begin
                            if (w_tgt && (r_eidx < w_len)) begin
                                o_cmd.mem_we = (i_op == csts_pkg::OP_STORE);
                                o_cmd.q_we   = (i_op == csts_pkg::OP_QUERY);
                            end
                            n_eidx = w_idx_n;
                            if (i_last) begin
                                n_eidx  = '0;
                                n_zi    = w_filled;
                                n_zq    = (i_op == csts_pkg::OP_QUERY);
                                n_scan  = 1'b0;
                                n_slot  = r_stored[SW-1:0];
                                n_ei    = '0;
                                n_found = '0;
                                o_cmd.out_last = 1'b1;
                                if (i_op == csts_pkg::OP_STORE) begin
                                    o_cmd.out_load = 1'b1;
                                    if (w_room) begin
                                        o_cmd.out_status = csts_pkg::ST_STORED;
                                        o_out_id = 12'(r_stored + 2'd2);
                                        n_stored = r_stored + 1'b1;
                                    end else begin
                                        o_cmd.out_status = csts_pkg::ST_FULL;
                                    end
                                end else begin
                                    n_slot = '0;
                                    if (r_stored == '0) begin
                                        o_cmd.out_load   = 1'b1;
                                        o_cmd.out_status = csts_pkg::ST_EMPTY;
                                    end else begin
                                        n_scan = 1'b1;
                                    end
                                end
                                if (w_tgt && (32'(w_filled) < MAX_DIM)) begin
                                    n_state = S_ZFILL;
                                end else if ((i_op == csts_pkg::OP_QUERY) &&
                                             (r_stored != '0)) begin
                                    n_state = w_scan_st;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_ZFILL: begin
                o_idx = r_zi[DW-1:0];
                o_cmd.wr_zero = 1'b1;
                o_cmd.mem_we  = !r_zq;
                o_cmd.q_we    = r_zq;
                n_zi = r_zi + 1'b1;
                if (32'(r_zi) == MAX_DIM - 1) begin
                    n_state = (r_zq && r_scan) ? w_scan_st : S_IDLE;
                end
            end
            S_RD: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.acc_clr = (r_ei == '0);
                if (r_ei == w_len - 1'b1) begin
                    n_cnt   = '0;
                    n_state = S_DRAIN;
                end else begin
                    n_ei = r_ei + 1'b1;
                end
            end
            S_DRAIN: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNW'(1)) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_cnt = '0;
                if (i_sts.ma_zero || i_sts.mb_zero) begin
                    n_simz  = 1'b1;
                    n_state = (r_thr == 15'd0) ? S_EMIT : S_NEXT;
                end else if (i_sts.dot_neg) begin
                    n_state = S_NEXT;
                end else begin
                    o_cmd.dp_op = csts_pkg::DP_MULP_INIT;
                    n_state = S_MULP;
                end
            end
            S_MULP: begin
                o_cmd.dp_op = csts_pkg::DP_MUL_STEP;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNW'(AW - 1)) begin
                    n_state = S_MULD_I;
                end
            end
            S_MULD_I: begin
                o_cmd.dp_op = csts_pkg::DP_MULD_INIT;
                n_cnt   = '0;
                n_state = S_MULD;
            end
            S_MULD: begin
                o_cmd.dp_op = csts_pkg::DP_MUL_STEP;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNW'(AW - 1)) begin
                    n_state = S_DIV_I;
                end
            end
            S_DIV_I: begin
                o_cmd.dp_op = csts_pkg::DP_DIV_INIT;
                n_cnt   = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.dp_op = csts_pkg::DP_DIV_STEP;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNW'(csts_pkg::DIV_STEPS - 1)) begin
                    n_state = S_SQRT_I;
                end
            end
            S_SQRT_I: begin
                o_cmd.dp_op = csts_pkg::DP_SQRT_INIT;
                n_cnt   = '0;
                n_state = S_SQRT;
            end
            S_SQRT: begin
                o_cmd.dp_op = csts_pkg::DP_SQRT_STEP;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNW'(csts_pkg::SQRT_STEPS - 1)) begin
                    n_state = S_JUDGE;
                end
            end
            S_JUDGE: begin
                n_simz  = 1'b0;
                n_state = (i_sts.sim >= r_thr) ? S_EMIT : S_NEXT;
            end
            S_EMIT: begin
                o_out_id = 12'(CW'(r_slot) + 2'd2);
                if (w_ofree) begin
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_status = csts_pkg::ST_MATCH;
                    o_cmd.out_sim_en = !r_simz;
                    n_found = r_found + 1'b1;
                    n_state = S_NEXT;
                end
            end
            S_NEXT: begin
                if (((CW'(r_slot) + 1'b1) < r_stored) && (r_found < r_maxm)) begin
                    n_slot  = r_slot + 1'b1;
                    n_ei    = '0;
                    n_state = S_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                o_out_count = r_found;
                if (w_ofree) begin
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_status = csts_pkg::ST_DONE;
                    o_cmd.out_last   = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_vlen      <= csts_pkg::VLEN_RST;
            r_thr       <= csts_pkg::THR_RST;
            r_maxm      <= csts_pkg::MAXM_RST;
            r_stored    <= '0;
            r_eidx      <= '0;
            r_slot      <= '0;
            r_zi        <= '0;
            r_zq        <= 1'b0;
            r_scan      <= 1'b0;
            r_ei        <= '0;
            r_cnt       <= '0;
            r_found     <= '0;
            r_simz      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_stored <= n_stored;
            r_eidx   <= n_eidx;
            r_slot   <= n_slot;
            r_zi     <= n_zi;
            r_zq     <= n_zq;
            r_scan   <= n_scan;
            r_ei     <= n_ei;
            r_cnt    <= n_cnt;
            r_found  <= n_found;
            r_simz   <= n_simz;
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    csts_pkg::CFG_VLEN: r_vlen <= i_cfg_data[5:0];
                    csts_pkg::CFG_THR:  r_thr  <= i_cfg_data[14:0];
                    csts_pkg::CFG_MAXM: r_maxm <= i_cfg_data[5:0];
                    default: ;
                endcase
            end
        end
    end

endmodule
`default_nettype wire

@@ rtl/cosine_similarity_threshold_search.sv @@
`default_nettype none
// Cosine similarity threshold search.
// i_in: one beat per vector element (operation, element_value, last_element).
// Non-last elements give no result. A store's last element gives a
// stored/full beat in the next cycle; a clear gives a cleared beat. A vector
// shorter than MAX_DIM is padded with zeros by a sweep over the remaining
// elements after its last element, input held off meanwhile.
// A query's last element starts a scan of the stored vectors in order (an
// empty beat if none are stored); per slot: vector_length reads, the
// pipeline drain and a check, then for nonzero magnitudes and a nonnegative
// dot product the shift-add multiplies, the divider and square-root steps
// and a compare. Matches go out as they are found, then a done beat.
// o_out: one registered result beat; when the receiver stalls the scan and
// the input wait, and a new item is taken in the cycle the beat leaves.
// i_cfg: always ready, write only while idle.
// Reset (synchronous, active low) empties the store and loads the register
// defaults; stored contents are not cleared.
module cosine_similarity_threshold_search #(
    parameter int MAX_VECTORS = csts_pkg::MAX_VECTORS_DEF,
    parameter int MAX_DIM     = csts_pkg::MAX_DIM_DEF
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    csts_cfg_if.sink   i_cfg,
    csts_in_if.sink    i_in,
    csts_out_if.source o_out
);
    localparam int SW = $clog2(MAX_VECTORS);
    localparam int DW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

    csts_pkg::t_cmd  w_cmd;
    csts_pkg::t_sts  w_sts;
    logic [SW-1:0]   w_slot;
    logic [DW-1:0]   w_idx;
    logic [11:0]     w_out_id;
    logic [5:0]      w_out_count;

    csts_ctrl #(.MAX_VECTORS(MAX_VECTORS), .MAX_DIM(MAX_DIM)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg.valid),
        .i_cfg_index (i_cfg.index),
        .i_cfg_data  (i_cfg.data),
        .o_cfg_ready (i_cfg.ready),
        .i_in_valid  (i_in.valid),
        .i_op        (i_in.operation),
        .i_last      (i_in.last_element),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd),
        .o_slot      (w_slot),
        .o_idx       (w_idx),
        .o_out_id    (w_out_id),
        .o_out_count (w_out_count)
    );

    csts_dp #(.MAX_VECTORS(MAX_VECTORS), .MAX_DIM(MAX_DIM)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_slot        (w_slot),
        .i_idx         (w_idx),
        .i_value       (i_in.element_value),
        .i_out_id      (w_out_id),
        .i_out_count   (w_out_count),
        .o_sts         (w_sts),
        .o_status      (o_out.status),
        .o_concept_id  (o_out.concept_id),
        .o_similarity  (o_out.similarity),
        .o_match_count (o_out.match_count),
        .o_last_result (o_out.last_result)
    );

endmodule
`default_nettype wire

@@ rtl/csts_checker.sv @@
`default_nettype none
module csts_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_in_ready,
    input wire        i_out_valid,
    input wire        i_out_ready,
    input wire [2:0]  i_status,
    input wire [11:0] i_concept_id,
    input wire        i_last_result
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_status) && $stable(i_concept_id))
        else $error("stalled result beat changed");

    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ((i_status == csts_pkg::ST_MATCH) != i_last_result))
        else $error("last flag wrong for status");

    a_id_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status != csts_pkg::ST_STORED) && (i_status != csts_pkg::ST_MATCH)
        |-> (i_concept_id == 12'd0))
        else $error("nonzero id on non-id result");

    a_stall_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |-> !i_in_ready)
        else $error("input taken while result stalled");

endmodule

bind cosine_similarity_threshold_search csts_checker u_csts_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_status      (o_out.status),
    .i_concept_id  (o_out.concept_id),
    .i_last_result (o_out.last_result)
);
`default_nettype wire

@@ verif/cosine_similarity_threshold_search_tb.sv @@
`default_nettype none
module cosine_similarity_threshold_search_tb;
    import csts_pkg::*;

    localparam logic [1:0] OP_NOP = 2'd3;
    localparam int NSLOT = MAX_VECTORS_DEF;
    localparam int NDIM  = MAX_DIM_DEF;
    localparam int STALL_LIMIT = 60000;

    typedef struct packed {
        logic [2:0]  status;
        logic [11:0] id;
        logic [14:0] sim;
        logic [5:0]  cnt;
        logic        last;
    } t_result;

    typedef struct {
        logic [1:0]  op;
        shortint     val;
        bit          last;
        int          rep;
        bit          chk;
        logic [2:0]  st;
        logic [11:0] id;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    csts_cfg_if cfg_if ();
    csts_in_if  in_if ();
    csts_out_if out_if ();

    cosine_similarity_threshold_search i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always #5 i_clk = ~i_clk;

    // mirror of the block
    shortint      vec_mem [NSLOT][NDIM];
    shortint      qry_vec [NDIM];
    int           n_stored;
    int           elem_pos;
    logic [5:0]   len_reg;
    logic [14:0]  thr_reg;
    logic [5:0]  maxm_reg;
    bit           qry_defined;

    t_result      pending_q [$];
    int           errors;
    int           in_idle;
    int           out_idle;
    int           hold_cycles;
    int           quiet_cycles;

    function automatic bit slot_match(input int slot, input int len, output logic [14:0] sim);
        longint a, b, dot, ma, mb;
        logic [127:0] rhs, lhs, dw;
        int lo, hi, mid;
        dot = 0; ma = 0; mb = 0;
        for (int i = 0; i < len; i++) begin
            a = qry_vec[i];
            b = vec_mem[slot][i];
            dot += a * b;
            ma += a * a;
            mb += b * b;
        end
        sim = '0;
        if (ma == 0 || mb == 0) return thr_reg == 0;
        if (dot < 0) return 1'b0;
        dw = dot;
        rhs = (dw * dw) << 30;
        lo = 0;
        hi = 32767;
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            lhs = 128'(mid) * 128'(mid) * 128'(ma) * 128'(mb);
            if (lhs <= rhs) lo = mid; else hi = mid - 1;
        end
        sim = lo[14:0];
        return lo >= thr_reg;
    endfunction

    task automatic add_result(input logic [2:0] st, input int id, input logic [14:0] sim,
                              input int cnt, input logic lst);
        pending_q.push_back('{st, id[11:0], sim, cnt[5:0], lst});
    endtask

    task automatic predict(input logic [1:0] op, input shortint v, input bit lst);
        int len, idx, filled, found;
        bit room;
        logic [14:0] sim;
        len = (len_reg == 0) ? 1 : ((len_reg > NDIM) ? NDIM : len_reg);
        if (op == OP_NOP) return;
        if (op == OP_CLEAR) begin
            n_stored = 0;
            elem_pos = 0;
            add_result(ST_CLEARED, 0, 0, 0, 1'b1);
            return;
        end
        room = n_stored < NSLOT;
        idx = elem_pos;
        if (idx < len) begin
            if (op == OP_STORE && room) vec_mem[n_stored][idx] = v;
            else if (op == OP_QUERY) qry_vec[idx] = v;
        end
        if (idx < NDIM) idx++;
        elem_pos = idx;
        if (!lst) return;
        elem_pos = 0;
        filled = (idx < len) ? idx : len;
        for (int k = filled; k < NDIM; k++) begin
            if (op == OP_STORE && room) vec_mem[n_stored][k] = 0;
            else if (op == OP_QUERY) qry_vec[k] = 0;
        end
        if (op == OP_STORE) begin
            if (!room) begin
                add_result(ST_FULL, 0, 0, 0, 1'b1);
            end else begin
                add_result(ST_STORED, n_stored + 2, 0, 0, 1'b1);
                n_stored++;
            end
            return;
        end
        qry_defined = 1'b1;
        if (n_stored == 0) begin
            add_result(ST_EMPTY, 0, 0, 0, 1'b1);
            return;
        end
        found = 0;
        for (int s = 0; s < n_stored && found < maxm_reg; s++) begin
            if (slot_match(s, len, sim)) begin
                add_result(ST_MATCH, s + 2, sim, 0, 1'b0);
                found++;
            end
        end
        add_result(ST_DONE, 0, 0, found, 1'b1);
    endtask

    // one element beat
    task automatic push(input logic [1:0] op, input shortint v, input bit lst);
        while ($urandom_range(99) < in_idle) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid         <= 1'b1;
        in_if.operation     <= op;
        in_if.element_value <= v;
        in_if.last_element  <= lst;
        do @(posedge i_clk); while (!in_if.ready);
        predict(op, v, lst);
    endtask

    task automatic drain(input int settle);
        in_if.valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [15:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        case (idx)
            CFG_VLEN: len_reg  = data[5:0];
            CFG_THR:  thr_reg  = data[14:0];
            CFG_MAXM: maxm_reg = data[5:0];
            default: ;
        endcase
    endtask

    task automatic configure(input int vl, input int th, input int mm);
        drain(64);
        cfg_write(CFG_VLEN, 16'(vl));
        cfg_write(CFG_THR, 16'(th));
        cfg_write(CFG_MAXM, 16'(mm));
    endtask

    function automatic shortint pick_val(input shortint base);
        case ($urandom_range(9))
            0: return shortint'($urandom);
            1: return 16'sh7fff;
            2: return 16'sh8000;
            3: return 0;
            default: return base + shortint'($urandom_range(4000)) - 16'sd2000;
        endcase
    endfunction

    task automatic send_vec(input logic [1:0] op, input int n, ref shortint base [NDIM]);
        for (int i = 0; i < n; i++) push(op, pick_val(base[i % NDIM]), i == n - 1);
    endtask

    // receiver and checker
    always @(posedge i_clk) begin
        t_result got, want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got = '{out_if.status, out_if.concept_id, out_if.similarity,
                    out_if.match_count, out_if.last_result};
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected beat %p", $time, got);
                errors++;
            end else begin
                want = pending_q.pop_front();
                if (got != want) begin
                    $display("%0t: mismatch expected %p actual %p", $time, want, got);
                    errors++;
                end
            end
        end
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= ($urandom_range(99) >= out_idle);
        end
    end

    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)
            || (cfg_if.valid && cfg_if.ready) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: timeout", $time);
            $display("cosine_similarity_threshold_search_tb failed");
            $finish;
        end
    end

    initial begin
        t_row rows [];
        shortint base [NDIM];
        int sent, n, len;
        in_if.valid = 1'b0;
        in_if.operation = OP_STORE;
        in_if.element_value = 0;
        in_if.last_element = 1'b0;
        out_if.ready = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.index = CFG_VLEN;
        cfg_if.data = 0;
        errors = 0;
        hold_cycles = 0;
        quiet_cycles = 0;
        n_stored = 0;
        elem_pos = 0;
        qry_defined = 1'b0;
        len_reg = VLEN_RST;
        thr_reg = THR_RST;
        maxm_reg = MAXM_RST;
        in_idle = 7;
        out_idle = 68;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        rows = '{
            '{OP_QUERY, 0, 1, 1, 1, ST_EMPTY, 0},
            '{OP_NOP, 123, 1, 1, 0, 0, 0},
            '{OP_STORE, 32767, 0, 1, 0, 0, 0},
            '{OP_STORE, -32768, 1, 1, 1, ST_STORED, 2},
            '{OP_STORE, -32768, 1, 1, 1, ST_STORED, 3},
            '{OP_STORE, 0, 1, 1, 1, ST_STORED, 4},
            '{OP_QUERY, 32767, 0, 1, 0, 0, 0},
            '{OP_QUERY, -32768, 1, 1, 0, 0, 0},
            '{OP_QUERY, 0, 1, 1, 1, ST_DONE, 0},
            '{OP_QUERY, -32768, 1, 1, 0, 0, 0},
            '{OP_STORE, 5, 0, 1, 0, 0, 0},
            '{OP_QUERY, 100, 1, 1, 0, 0, 0},
            '{OP_QUERY, 7, 0, 1, 0, 0, 0},
            '{OP_CLEAR, 0, 0, 1, 1, ST_CLEARED, 0},
            '{OP_STORE, 1, 1, 34, 1, ST_STORED, 2},
            '{OP_QUERY, 1, 1, 34, 0, 0, 0},
            '{OP_CLEAR, -1, 1, 1, 1, ST_CLEARED, 0}
        };
        foreach (rows[r]) begin
            for (int k = 0; k < rows[r].rep; k++)
                push(rows[r].op, rows[r].val, rows[r].last && k == rows[r].rep - 1);
            if (rows[r].chk && (pending_q.size() == 0 || pending_q[$].status != rows[r].st
                                || pending_q[$].id != rows[r].id)) begin
                $display("%0t: row %0d expected status %0d id %0d, actual %p",
                         $time, r, rows[r].st, rows[r].id, pending_q[$]);
                errors++;
            end
        end

        // fill the store to its limit, one refused, then empty it
        configure(1, 0, 63);
        for (int i = 0; i <= NSLOT; i++) push(OP_STORE, shortint'($urandom), 1'b1);
        push(OP_QUERY, 0, 1'b1);
        push(OP_CLEAR, 0, 1'b0);

        sent = 0;
        for (int ph = 0; ph < 9; ph++) begin
            case (ph)
                0: configure(1, 0, 63);
                1: configure(32, 32767, 1);
                2: configure(0, 16384, 0);
                3: configure(63, 8000, 5);
                4: configure(4, 30000, 2);
                default: configure($urandom_range(63), $urandom_range(32767),
                                   $urandom_range(63));
            endcase
            if (ph == 3) begin
                in_idle = 68;
                out_idle = 7;
            end else if (ph == 6) begin
                in_idle = 0;
                out_idle = 0;
            end
            len = (len_reg == 0) ? 1 : ((len_reg > NDIM) ? NDIM : len_reg);
            foreach (base[i]) base[i] = shortint'($urandom);
            if (ph == 4) begin
                hold_cycles = 400;
                for (int v = 0; v < 4; v++) send_vec(OP_STORE, len, base);
                send_vec(OP_QUERY, len, base);
                drain(0);
            end
            while (sent < 34 * (ph + 1)) begin
                n = len + $urandom_range(2) - ($urandom_range(3) == 0 ? 1 : 0);
                if (n < 1) n = 1;
                case ($urandom_range(19))
                    0, 1, 2, 3, 4, 5, 6: begin
                        if (n_stored >= 8) push(OP_CLEAR, 0, $urandom_range(1));
                        send_vec(OP_STORE, n, base);
                    end
                    7, 8, 9, 10, 11, 12, 13: send_vec(OP_QUERY, n, base);
                    14: push(OP_NOP, shortint'($urandom), $urandom_range(1));
                    15: push(OP_CLEAR, shortint'($urandom), $urandom_range(1));
                    16: if (qry_defined) begin
                        for (int i = 0; i < n - 1; i++)
                            push($urandom_range(1) ? OP_QUERY : OP_STORE,
                                 pick_val(base[i % NDIM]), 1'b0);
                        push(OP_QUERY, pick_val(base[0]), 1'b1);
                    end
                    17: begin
                        push(OP_QUERY, pick_val(base[0]), 1'b0);
                        push(OP_CLEAR, 0, 1'b0);
                    end
                    default: foreach (base[i]) base[i] = shortint'($urandom);
                endcase
                sent += n;
            end
        end

        drain(200);
        if (errors == 0)
            $display("cosine_similarity_threshold_search_tb passed");
        else
            $display("cosine_similarity_threshold_search_tb failed");
        $finish;
    end

endmodule
`default_nettype wire
